/* sv/lcdsr_pkg.sv */
// Shared types and constants for the character LCD shadow refresh unit.
// Used by lcdsr_buffer and char_lcd_shadow_refresh_unit; depends on nothing.
package lcdsr_pkg;

  localparam int LINE_LENGTH = 16;
  localparam int LINE_COUNT  = 2;

  // Host operation codes.
  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_SET_CUR   = 3'd2,
    OP_LINE_CHAR = 3'd3,
    OP_TICK      = 3'd4,
    OP_RAW       = 3'd5
  } op_e;

  // Register word index on the configuration port.
  localparam logic REG_INTERVAL = 1'b0;

  localparam logic [7:0] SPACE_CHAR     = 8'h20;
  localparam logic [7:0] CMD_ROW0_ADDR  = 8'h02;
  localparam logic [7:0] CMD_ROW1_ADDR  = 8'hC0;
  localparam logic [7:0] INTERVAL_RESET = 8'd2;
  localparam logic [2:0] INIT_LAST_IDX  = 3'd6;

  // Control flags from the sequencer to the buffer.
  typedef struct packed {
    logic we;       // store one character
    logic re;       // read one character
    logic clr_all;  // whole buffer back to spaces
    logic pad;      // tail of one line back to spaces
  } lcdsr_buf_ctrl_t;

  // Panel start-up sequence, all command bytes.
  function automatic logic [7:0] start_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0, 3'd1, 3'd2, 3'd3: b = 8'h38;
      3'd4:                   b = 8'h0C;
      3'd5:                   b = 8'h06;
      3'd6:                   b = 8'h01;
      default:                b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

/* sv/lcdsr_buffer.sv */
// Character shadow buffer: one synchronous memory with a registered read port.
// Per-entry valid bits make a cleared entry read as a space. Uses lcdsr_pkg.
module lcdsr_buffer #(
  parameter int LineLength = lcdsr_pkg::LINE_LENGTH,
  parameter int LineCount  = lcdsr_pkg::LINE_COUNT,
  localparam int Depth     = LineLength * LineCount,
  localparam int AddrW     = $clog2(Depth),
  localparam int ColW      = $clog2(LineLength + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lcdsr_pkg::lcdsr_buf_ctrl_t ctrl_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  input  logic                       pad_line_i,
  input  logic [ColW-1:0]            pad_from_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q  <= mem_q[raddr_i];
      rvalid_q <= valid_q[raddr_i];
    end
  end

  // A pad clears every entry of the chosen line from the fill column on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (ctrl_i.clr_all) begin
          valid_q[i] <= 1'b0;
        end else if (ctrl_i.pad && (i / LineLength == int'(pad_line_i)) &&
                     (i % LineLength >= int'(pad_from_i))) begin
          valid_q[i] <= 1'b0;
        end else if (ctrl_i.we && (int'(waddr_i) == i)) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : lcdsr_pkg::SPACE_CHAR;

endmodule

/* sv/char_lcd_shadow_refresh_unit.sv */
// Top level of the character LCD shadow refresh unit: host sequencer, refresh
// timer, output register and configuration port. Uses lcdsr_pkg, lcdsr_buffer.

// The unit keeps a LineCount x LineLength character shadow of the panel and
// sends it out one byte per refresh interval, counted in millisecond tick
// items. Buffer writes, cursor sets, line characters (including the space
// padding of a line end, done at once through the valid bits) and ticks that
// send nothing finish in their accept cycle. A tick that sends a character
// goes through the buffer memory read, the staging register, and the load of
// the output register, which waits for a free output slot; a line-address
// tick and a raw command skip the read. Init clears the buffer in its accept
// cycle, then loads the seven start-up bytes in turn as the output register is drained.
// An item is taken only while no earlier byte is still being staged and no
// start-up bytes are still being sent, but the output register lets the next item in while a byte waits for the sink.
// The refresh interval register sits at byte address 0 and resets to 2.
module char_lcd_shadow_refresh_unit #(
  parameter int LineLength = lcdsr_pkg::LINE_LENGTH,
  parameter int LineCount  = lcdsr_pkg::LINE_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Host items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic        line_i,
  input  logic [3:0]  column_i,
  input  logic [7:0]  char_data_i,
  // Panel bytes
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_data_o,
  output logic [7:0]  lcd_byte_o,
  output logic        last_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Depth  = LineLength * LineCount;
  localparam int AddrW  = $clog2(Depth);
  localparam int ColW   = $clog2(LineLength + 1);
  localparam int CurMax = (2 * LineLength > LineLength + 15) ? 2 * LineLength
                                                             : LineLength + 15;
  localparam int CurW   = $clog2(CurMax + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_INIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [7:0]      interval_q;
  logic [CurW-1:0] cursor_q, cursor_d;
  logic [ColW-1:0] fill_q, fill_d;
  logic            row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [7:0]      ms_q, ms_d;
  logic [2:0]      init_cnt_q, init_cnt_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  logic            pend_is_data_q, pend_is_data_d;

  logic            out_valid_q, out_valid_d;
  logic            out_is_data_q, out_is_data_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  lcdsr_pkg::lcdsr_buf_ctrl_t buf_ctrl;
  logic [AddrW-1:0] buf_waddr, buf_raddr;
  logic [7:0]       buf_wdata, buf_rdata;

  logic            accept;
  logic            slot_free;
  logic            line_ok;
  logic [CurW-1:0] cursor_wr;
  logic [7:0]      ms_inc;
  logic [AddrW-1:0] line_base, row_base;
  logic            cfg_write;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign line_ok    = int'(line_i) < LineCount;
  assign cursor_wr  = (cursor_q >= CurW'(Depth)) ? '0 : cursor_q;
  assign ms_inc     = (ms_q == 8'hFF) ? ms_q : ms_q + 8'd1;
  assign line_base  = line_i ? AddrW'(LineLength) : '0;
  assign row_base   = row_q ? AddrW'(LineLength) : '0;

  always_comb begin
    state_d        = state_q;
    cursor_d       = cursor_q;
    fill_d         = fill_q;
    row_d          = row_q;
    col_d          = col_q;
    ms_d           = ms_q;
    init_cnt_d     = init_cnt_q;
    pend_byte_d    = pend_byte_q;
    pend_is_data_d = pend_is_data_q;
    buf_ctrl       = '0;
    buf_waddr      = cursor_wr[AddrW-1:0];
    buf_wdata      = char_data_i;
    buf_raddr      = row_base + AddrW'(col_q);
    out_valid_d    = out_valid_q && !out_ready_i;
    out_is_data_d  = out_is_data_q;
    out_byte_d     = out_byte_q;
    out_last_d     = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            lcdsr_pkg::OP_INIT: begin
              buf_ctrl.clr_all = 1'b1;
              cursor_d   = '0;
              fill_d     = '0;
              row_d      = 1'b0;
              col_d      = '0;
              ms_d       = '0;
              init_cnt_d = '0;
              state_d    = ST_INIT;
            end
            lcdsr_pkg::OP_WRITE: begin
              buf_ctrl.we = 1'b1;
              cursor_d    = cursor_wr + CurW'(1);
            end
            lcdsr_pkg::OP_SET_CUR: begin
              cursor_d = (line_i ? CurW'(LineLength) : '0) + CurW'(column_i);
            end
            lcdsr_pkg::OP_LINE_CHAR: begin
              if (char_data_i != 8'd0) begin
                if (fill_q < ColW'(LineLength)) begin
                  buf_ctrl.we = line_ok;
                  buf_waddr   = line_base + AddrW'(fill_q);
                  fill_d      = fill_q + ColW'(1);
                end
              end else begin
                buf_ctrl.pad = line_ok;
                cursor_d = line_i ? CurW'(2 * LineLength) : CurW'(LineLength);
                fill_d   = '0;
              end
            end
            lcdsr_pkg::OP_TICK: begin
              if (ms_inc >= interval_q) begin
                ms_d = '0;
                if (col_q >= ColW'(LineLength)) begin
                  // End of a line: move to the next row's address.
                  col_d          = '0;
                  row_d          = (LineCount > 1) ? ~row_q : 1'b0;
                  pend_byte_d    = row_d ? lcdsr_pkg::CMD_ROW1_ADDR
                                         : lcdsr_pkg::CMD_ROW0_ADDR;
                  pend_is_data_d = 1'b0;
                  state_d        = ST_EMIT;
                end else begin
                  buf_ctrl.re = 1'b1;
                  col_d       = col_q + ColW'(1);
                  state_d     = ST_READ;
                end
              end else begin
                ms_d = ms_inc;
              end
            end
            lcdsr_pkg::OP_RAW: begin
              pend_byte_d    = char_data_i;
              pend_is_data_d = 1'b0;
              state_d        = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        pend_byte_d    = buf_rdata;
        pend_is_data_d = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_is_data_d = pend_is_data_q;
          out_byte_d    = pend_byte_q;
          out_last_d    = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_is_data_d = 1'b0;
          out_byte_d    = lcdsr_pkg::start_byte(init_cnt_q);
          out_last_d    = (init_cnt_q == lcdsr_pkg::INIT_LAST_IDX);
          init_cnt_d    = init_cnt_q + 3'd1;
          if (init_cnt_q == lcdsr_pkg::INIT_LAST_IDX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  lcdsr_buffer #(
    .LineLength (LineLength),
    .LineCount  (LineCount)
  ) u_buffer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (buf_ctrl),
    .waddr_i    (buf_waddr),
    .wdata_i    (buf_wdata),
    .raddr_i    (buf_raddr),
    .pad_line_i (line_i),
    .pad_from_i (fill_q),
    .rdata_o    (buf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      fill_q      <= '0;
      row_q       <= 1'b0;
      col_q       <= '0;
      ms_q        <= '0;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      fill_q      <= fill_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ms_q        <= ms_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q    <= pend_byte_d;
    pend_is_data_q <= pend_is_data_d;
    out_is_data_q  <= out_is_data_d;
    out_byte_q     <= out_byte_d;
    out_last_q     <= out_last_d;
  end

  // Configuration port: the byte offset inside the word is ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == lcdsr_pkg::REG_INTERVAL);
  assign prdata    = (paddr[2] == lcdsr_pkg::REG_INTERVAL) ? {24'd0, interval_q}
                                                           : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= lcdsr_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      interval_q <= pwdata[7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = out_is_data_q;
  assign lcd_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

`ifndef SYNTH
  // Only start-up bytes come without the end-of-run mark, and they are commands.
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o || !is_data_o))
    else $error("character byte without last");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= ColW'(LineLength))
    else $error("refresh column out of range");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ColW'(LineLength))
    else $error("fill column out of range");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CurW'(CurMax))
    else $error("write cursor out of range");

  // A buffer read always hands its byte to the staging cycle next.
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_ctrl.re |=> (state_q == ST_READ))
    else $error("buffer read lost");
`endif

endmodule
